FILE: rtl/icpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpe_pkg: shared types and constants of the ir code pair expander
// Holds the operation codes, result kinds, sequencer states and field widths.
// ----------------------------------------------------------------------------
package icpe_pkg;

  // field widths of one input beat
  localparam int unsigned OPCODE_W  = 2;
  localparam int unsigned TIDX_W    = 5;
  localparam int unsigned TVAL_W    = 16;
  localparam int unsigned PAIRS_W   = 8;
  localparam int unsigned BPI_W     = 3;
  localparam int unsigned KHZ_W     = 8;
  localparam int unsigned BYTE_W    = 8;

  // field widths of one output beat
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned DUR_W     = 20;
  localparam int unsigned HZ_W      = 18;

  // bit counter of the code byte shifter, holds 0..8
  localparam int unsigned BITCNT_W  = 4;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_BYTE  = 2'd2
  } opcode_e;

  typedef enum logic [KIND_W-1:0] {
    RK_TIMING = 2'd0,
    RK_ACCEPT = 2'd1,
    RK_REJECT = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_MARK,
    S_SPACE
  } state_e;

endpackage

FILE: rtl/icpe_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icpe_table: timing table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module icpe_table
  import icpe_pkg::*;
#(
  parameter int unsigned ADDR_W = 5
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [ADDR_W-1:0]   wr_addr_i,
  input  logic [TVAL_W-1:0]   wr_data_i,
  input  logic [ADDR_W-1:0]   rd_addr_i,
  output logic [TVAL_W-1:0]   rd_data_o
);

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [TVAL_W-1:0] mem_q [DEPTH];
  logic [TVAL_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/ir_code_pair_expander_unit.sv
`timescale 1ns / 1ps
// An accept or reject beat is registered and shown in the cycle after its
// start beat is taken. The mark of an index is read from the table once the
// last bit of that index is shifted and is registered in S_MARK, its space in
// S_SPACE; both wait while the output stalls. A code byte is shifted out in
// S_SHIFT between the pairs that it emits, and its handling ends inside the
// byte when the code ends. A new beat is taken only when idle and the output
// is free, so no new byte is taken before the last one is done.
// Reset clears the sequencer, code state and output valid; the timing table
// is not cleared and reads as undefined until written.
// ----------------------------------------------------------------------------
// ir_code_pair_expander_unit: bit-packed infrared code to mark/space timings
// Shifts each code byte out one bit a cycle in S_SHIFT, gathers table indices
// and looks up mark and space durations, scaled from 10 us units to microseconds.
// ----------------------------------------------------------------------------
module ir_code_pair_expander_unit
  import icpe_pkg::*;
#(
  parameter int unsigned MAX_TIMINGS = 512,
  parameter int unsigned INDEX_BITS  = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [OPCODE_W-1:0] opcode_i,
  input  logic [TIDX_W-1:0]   table_index_i,
  input  logic [TVAL_W-1:0]   table_value_i,
  input  logic [PAIRS_W-1:0]  pair_count_i,
  input  logic [BPI_W-1:0]    bits_per_index_i,
  input  logic [KHZ_W-1:0]    carrier_khz_i,
  input  logic [BYTE_W-1:0]   code_byte_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [KIND_W-1:0]   result_kind_o,
  output logic [DUR_W-1:0]    duration_us_o,
  output logic                is_mark_o,
  output logic [HZ_W-1:0]     carrier_hz_o,
  output logic                last_o
);

  localparam int unsigned ADDR_W      = INDEX_BITS + 1;
  localparam int unsigned TABLE_DEPTH = 2 << INDEX_BITS;

  // sequencer and code state
  state_e                  state_q, state_d;
  logic                    active_q, active_d;
  logic [INDEX_BITS-1:0]   acc_q, acc_d;
  logic [BPI_W-1:0]        gathered_q, gathered_d;
  logic [PAIRS_W-1:0]      pairs_q, pairs_d;
  logic [BPI_W-1:0]        width_q, width_d;
  logic [BYTE_W-1:0]       byte_q, byte_d;
  logic [BITCNT_W-1:0]     bits_left_q, bits_left_d;
  logic [ADDR_W-1:0]       rd_addr_q, rd_addr_d;

  // output register
  logic                    out_valid_q, out_valid_d;
  logic [KIND_W-1:0]       kind_q, kind_d;
  logic [DUR_W-1:0]        dur_q, dur_d;
  logic                    mark_q, mark_d;
  logic [HZ_W-1:0]         hz_q, hz_d;
  logic                    last_q, last_d;

  logic                    out_free;
  logic                    in_accept;
  logic                    tbl_wr_en;
  logic [TVAL_W-1:0]       tbl_rd_data;
  logic [INDEX_BITS:0]     acc_shift;
  logic [BPI_W-1:0]        gathered_inc;
  logic                    index_done;
  logic                    start_bad;
  logic [HZ_W-1:0]         khz_ext;
  logic [HZ_W-1:0]         carrier_hz;
  logic [DUR_W-1:0]        rd_scaled;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && out_free);
  assign in_accept  = in_valid_i && !in_stall_o;

  // table write on a load beat inside the table range
  assign tbl_wr_en = in_accept && (opcode_i == OP_LOAD)
                     && (32'(table_index_i) < 32'(TABLE_DEPTH));

  icpe_table #(
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (ADDR_W'(table_index_i)),
    .wr_data_i (table_value_i),
    .rd_addr_i (rd_addr_d),
    .rd_data_o (tbl_rd_data)
  );

  // one bit a cycle into the index accumulator while in S_SHIFT
  assign acc_shift    = {acc_q, byte_q[BYTE_W-1]};
  assign gathered_inc = gathered_q + 1'b1;
  assign index_done   = (gathered_inc == width_q);

  // start checks and carrier scaling, khz*1000 = khz*1024 - khz*16 - khz*8
  assign start_bad  = (pair_count_i == '0) || (bits_per_index_i == '0)
                      || (32'({pair_count_i, 1'b0}) > 32'(MAX_TIMINGS));
  assign khz_ext    = HZ_W'(carrier_khz_i);
  assign carrier_hz = (khz_ext << 10) - (khz_ext << 4) - (khz_ext << 3);

  // table entry times ten
  assign rd_scaled = (DUR_W'(tbl_rd_data) << 3) + (DUR_W'(tbl_rd_data) << 1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && (opcode_i == OP_BYTE) && active_q) begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (index_done) begin
          state_d = S_MARK;
        end else if (bits_left_q == BITCNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end
      S_MARK: begin
        if (out_free) begin
          state_d = S_SPACE;
        end
      end
      S_SPACE: begin
        if (out_free) begin
          if ((pairs_q == '0) || (bits_left_q == '0)) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_SHIFT;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and output register loads
  always_comb begin
    active_d    = active_q;
    acc_d       = acc_q;
    gathered_d  = gathered_q;
    pairs_d     = pairs_q;
    width_d     = width_q;
    byte_d      = byte_q;
    bits_left_d = bits_left_q;
    rd_addr_d   = rd_addr_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    dur_d       = dur_q;
    mark_d      = mark_q;
    hz_d        = hz_q;
    last_d      = last_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          case (opcode_i)
            OP_START: begin
              acc_d       = '0;
              gathered_d  = '0;
              out_valid_d = 1'b1;
              dur_d       = '0;
              mark_d      = 1'b0;
              last_d      = 1'b0;
              if (start_bad) begin
                active_d = 1'b0;
                pairs_d  = '0;
                width_d  = '0;
                kind_d   = RK_REJECT;
                hz_d     = '0;
              end else begin
                active_d = 1'b1;
                pairs_d  = pair_count_i;
                width_d  = bits_per_index_i;
                kind_d   = RK_ACCEPT;
                hz_d     = carrier_hz;
              end
            end
            OP_BYTE: begin
              if (active_q) begin
                byte_d      = code_byte_i;
                bits_left_d = BITCNT_W'(BYTE_W);
              end
            end
            default: ;
          endcase
        end
      end
      S_SHIFT: begin
        byte_d      = byte_q << 1;
        bits_left_d = bits_left_q - 1'b1;
        if (index_done) begin
          rd_addr_d  = {acc_shift[INDEX_BITS-1:0], 1'b0};
          pairs_d    = pairs_q - 1'b1;
          acc_d      = '0;
          gathered_d = '0;
        end else begin
          acc_d      = acc_shift[INDEX_BITS-1:0];
          gathered_d = gathered_inc;
        end
      end
      S_MARK: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = RK_TIMING;
          dur_d       = rd_scaled;
          mark_d      = 1'b1;
          hz_d        = '0;
          last_d      = 1'b0;
          rd_addr_d   = rd_addr_q | ADDR_W'(1);
        end
      end
      S_SPACE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          kind_d      = RK_TIMING;
          dur_d       = rd_scaled;
          mark_d      = 1'b0;
          hz_d        = '0;
          last_d      = (pairs_q == '0);
          if (pairs_q == '0) begin
            active_d = 1'b0;
            width_d  = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= 1'b0;
      acc_q       <= '0;
      gathered_q  <= '0;
      pairs_q     <= '0;
      width_q     <= '0;
      bits_left_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      acc_q       <= acc_d;
      gathered_q  <= gathered_d;
      pairs_q     <= pairs_d;
      width_q     <= width_d;
      bits_left_q <= bits_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    rd_addr_q <= rd_addr_d;
    kind_q    <= kind_d;
    dur_q     <= dur_d;
    mark_q    <= mark_d;
    hz_q      <= hz_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign duration_us_o = dur_q;
  assign is_mark_o     = mark_q;
  assign carrier_hz_o  = hz_q;
  assign last_o        = last_q;

`ifndef NO_ASSERTIONS
  // the byte sequencer only runs inside an active code
  a_busy_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> active_q)
    else $error("sequencer busy without an active code");

  // gathered bits stay below the index width while a code runs
  a_gather_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (gathered_q < width_q))
    else $error("gathered bit count reached the index width");

  // the last flag only marks a space timing
  a_last_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> ((result_kind_o == RK_TIMING) && !is_mark_o))
    else $error("last flag on a beat that is not a space");

  // a mark beat is always followed by its space
  a_mark_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK && out_free) |=> (state_q == S_SPACE))
    else $error("mark emitted without moving on to its space");
`endif

endmodule
